>>> hw/rtl/pmsc_pkg.sv
// Shared constants and types for the page map slot cache.
package pmsc_pkg;

  localparam int SLOTS      = 1024;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int LIM_W      = SLOT_W + 1;
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORDS      = SLOTS / WORD_BITS;
  localparam int WORD_W     = $clog2(WORDS);
  localparam int HASH_WAYS  = 8;
  localparam int WAY_W      = $clog2(HASH_WAYS);
  localparam int FRAME_BITS = 40;
  localparam int REFS_W     = 16;
  localparam int CFG_W      = 11;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  // Opcodes of an input beat.
  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_UNMAP = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_SLOT = 2'd1;
  localparam logic [1:0] ST_REFS    = 2'd2;

  // Control from the sequencer to the bitmap unit.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [LIM_W-1:0]  start;
    logic [LIM_W-1:0]  lim;
    logic              reclaim;
    logic              set_busy;
    logic              set_garbage;
    logic [SLOT_W-1:0] idx;
  } bm_ctl_t;

endpackage

>>> hw/rtl/pmsc_bitmap.sv
// Busy and garbage bitmaps with a one-word-per-cycle free slot finder.
module pmsc_bitmap
  import pmsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  bm_ctl_t          ctl,
  output logic             found,
  output logic [BIT_W-1:0] pos
);

  logic [WORD_BITS-1:0] busy_r    [WORDS];
  logic [WORD_BITS-1:0] garbage_r [WORDS];
  logic [WORD_BITS-1:0] lo_mask, hi_mask, cand;
  logic [WORD_W:0]      cur_w, start_w, lim_w;

  // Window the word to slots in [start, lim).
  always_comb begin
    cur_w   = {1'b0, ctl.word};
    start_w = ctl.start[LIM_W-1:BIT_W];
    lim_w   = ctl.lim[LIM_W-1:BIT_W];
    if (cur_w == start_w) lo_mask = {WORD_BITS{1'b1}} << ctl.start[BIT_W-1:0];
    else if (cur_w > start_w) lo_mask = '1;
    else lo_mask = '0;
    if (lim_w > cur_w) hi_mask = '1;
    else if (lim_w == cur_w)
      hi_mask = ({{(WORD_BITS-1){1'b0}}, 1'b1} << ctl.lim[BIT_W-1:0]) - 1'b1;
    else hi_mask = '0;
    cand = ~busy_r[ctl.word] & lo_mask & hi_mask;
  end

  // Pick the lowest free bit.
  always_comb begin
    found = |cand;
    pos   = '0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (cand[p]) pos = BIT_W'(p);
    end
  end

  // Reclaim a word, or set one busy or garbage bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < WORDS; j++) begin
        busy_r[j]    <= '0;
        garbage_r[j] <= '0;
      end
    end else if (ctl.reclaim) begin
      busy_r[ctl.word]    <= busy_r[ctl.word] & ~garbage_r[ctl.word];
      garbage_r[ctl.word] <= '0;
    end else begin
      if (ctl.set_busy)
        busy_r[ctl.idx[SLOT_W-1:BIT_W]][ctl.idx[BIT_W-1:0]] <= 1'b1;
      if (ctl.set_garbage)
        garbage_r[ctl.idx[SLOT_W-1:BIT_W]][ctl.idx[BIT_W-1:0]] <= 1'b1;
    end
  end

endmodule

>>> hw/rtl/page_map_slot_cache.sv
// Top level: sequencer, parked mapping ways and slot frame store.
// One beat at a time; an unmap of a slot past the limit skips the unmap step. A map
// miss walks the busy map one 64-bit word per cycle from the cursor (up to
// 16 words); a wrap adds a reclaim sweep over all 16 words, a second walk
// of up to 16 words and a look at up to 8 ways for eviction. A finished
// result waits in the output register while the next beat is taken.
module page_map_slot_cache
  import pmsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [FRAME_BITS-1:0] in_frame,
  input  logic [SLOT_W-1:0]     in_slot,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SLOT_W-1:0]     out_slot_out,
  output logic [FRAME_BITS-1:0] out_frame_out,
  output logic                  out_hash_hit,
  output logic                  out_flushed,
  output logic [1:0]            out_status
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PROBE  = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_RECL   = 8'b0000_1000,
    S_EVICT  = 8'b0001_0000,
    S_COMMIT = 8'b0010_0000,
    S_UNMAP  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [CFG_W-1:0]      cfg_r;
  logic [LIM_W-1:0]      lim;
  logic [LIM_W-1:0]      cursor_r, cursor_nxt;
  logic                  op_r;
  logic [FRAME_BITS-1:0] frame_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [WORD_W-1:0]     word_r, word_nxt;
  logic [LIM_W-1:0]      start_r, start_nxt;
  logic                  wrap_r, wrap_nxt;
  logic [WAY_W-1:0]      k_r, k_nxt;
  logic [WAY_W:0]        n_r, n_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;

  logic [SLOT_W-1:0]     rs_slot_r, rs_slot_nxt;
  logic [FRAME_BITS-1:0] rs_frame_r, rs_frame_nxt;
  logic                  rs_hit_r, rs_hit_nxt, rs_fl_r, rs_fl_nxt;
  logic [1:0]            rs_st_r, rs_st_nxt;

  logic                  out_valid_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [FRAME_BITS-1:0] out_frame_r;
  logic                  out_hit_r, out_fl_r;
  logic [1:0]            out_st_r;

  logic [FRAME_BITS-1:0] pframe_r [HASH_WAYS];
  logic [LIM_W-1:0]      pslot_r  [HASH_WAYS];
  logic [REFS_W-1:0]     prefs_r  [HASH_WAYS];
  logic [FRAME_BITS-1:0] frame_mem [SLOTS];
  logic [FRAME_BITS-1:0] rd_r;

  logic [WAY_W-1:0]      pw;
  logic                  pw_we;
  logic [FRAME_BITS-1:0] pw_frame;
  logic [LIM_W-1:0]      pw_slot;
  logic [REFS_W-1:0]     pw_refs;
  logic                  mem_we;
  bm_ctl_t               bm_ctl;
  logic                  bm_found;
  logic [BIT_W-1:0]      bm_pos;
  logic                  accept;
  logic                  out_load;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign lim       = (cfg_r > CFG_W'(SLOTS)) ? LIM_W'(SLOTS) : LIM_W'(cfg_r);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  pmsc_bitmap u_bitmap (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (bm_ctl),
    .found (bm_found),
    .pos   (bm_pos)
  );

  // Pick the way that this state looks at.
  always_comb begin
    if (state_r == S_EVICT) pw = k_r;
    else if (state_r == S_UNMAP) pw = rd_r[WAY_W-1:0];
    else pw = frame_r[WAY_W-1:0];
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    cursor_nxt   = cursor_r;
    word_nxt     = word_r;
    start_nxt    = start_r;
    wrap_nxt     = wrap_r;
    k_nxt        = k_r;
    n_nxt        = n_r;
    idx_nxt      = idx_r;
    rs_slot_nxt  = rs_slot_r;
    rs_frame_nxt = rs_frame_r;
    rs_hit_nxt   = 1'b0;
    rs_fl_nxt    = 1'b0;
    rs_st_nxt    = ST_OK;
    pw_we        = 1'b0;
    pw_frame     = pframe_r[pw];
    pw_slot      = pslot_r[pw];
    pw_refs      = prefs_r[pw];
    mem_we       = 1'b0;
    bm_ctl       = '0;
    bm_ctl.word  = word_r;
    bm_ctl.start = start_r;
    bm_ctl.lim   = lim;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_MAP) begin
            state_nxt = S_PROBE;
          end else if ({1'b0, in_slot} >= lim) begin
            rs_slot_nxt  = in_slot;
            rs_frame_nxt = '0;
            state_nxt    = S_OUT;
          end else begin
            state_nxt = S_UNMAP;
          end
        end
      end
      S_PROBE: begin
        rs_frame_nxt = frame_r;
        if (!pslot_r[pw][SLOT_W] && pframe_r[pw] == frame_r) begin
          rs_slot_nxt = pslot_r[pw][SLOT_W-1:0];
          rs_hit_nxt  = 1'b1;
          if (prefs_r[pw] == REFS_MAX) begin
            rs_st_nxt = ST_REFS;
          end else begin
            pw_we   = 1'b1;
            pw_refs = prefs_r[pw] + 1'b1;
          end
          state_nxt = S_OUT;
        end else if (cursor_r >= lim) begin
          word_nxt  = '0;
          wrap_nxt  = 1'b1;
          state_nxt = S_RECL;
        end else begin
          word_nxt  = cursor_r[SLOT_W-1:BIT_W];
          start_nxt = cursor_r;
          wrap_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (bm_found) begin
          idx_nxt   = {word_r, bm_pos};
          state_nxt = S_COMMIT;
        end else if ({({1'b0, word_r} + 1'b1), {BIT_W{1'b0}}} >= lim) begin
          if (!wrap_r) begin
            word_nxt  = '0;
            wrap_nxt  = 1'b1;
            state_nxt = S_RECL;
          end else begin
            k_nxt     = frame_r[WAY_W-1:0];
            n_nxt     = '0;
            state_nxt = S_EVICT;
          end
        end else begin
          word_nxt = word_r + 1'b1;
        end
      end
      S_RECL: begin
        bm_ctl.reclaim = 1'b1;
        word_nxt       = word_r + 1'b1;
        if (word_r == WORD_W'(WORDS - 1)) begin
          start_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_EVICT: begin
        if (pslot_r[pw] < lim && prefs_r[pw] == '0) begin
          idx_nxt   = pslot_r[pw][SLOT_W-1:0];
          pw_we     = 1'b1;
          pw_slot   = LIM_W'(SLOTS);
          pw_frame  = '1;
          state_nxt = S_COMMIT;
        end else begin
          k_nxt = k_r + 1'b1;
          n_nxt = n_r + 1'b1;
          if (n_r == (WAY_W+1)'(HASH_WAYS - 1)) begin
            rs_slot_nxt  = '0;
            rs_frame_nxt = frame_r;
            rs_fl_nxt    = 1'b1;
            rs_st_nxt    = ST_NO_SLOT;
            state_nxt    = S_OUT;
          end
        end
      end
      S_COMMIT: begin
        bm_ctl.set_busy = 1'b1;
        bm_ctl.idx      = idx_r;
        mem_we          = 1'b1;
        cursor_nxt      = LIM_W'(idx_r) + 1'b1;
        rs_slot_nxt     = idx_r;
        rs_frame_nxt    = frame_r;
        rs_fl_nxt       = wrap_r;
        state_nxt       = S_OUT;
      end
      S_UNMAP: begin
        rs_slot_nxt  = slot_r;
        rs_frame_nxt = rd_r;
        if (pslot_r[pw] == {1'b0, slot_r}) begin
          if (prefs_r[pw] == '0) begin
            rs_st_nxt = ST_REFS;
          end else begin
            pw_we   = 1'b1;
            pw_refs = prefs_r[pw] - 1'b1;
          end
        end else if (prefs_r[pw] == '0) begin
          bm_ctl.set_garbage = !pslot_r[pw][SLOT_W];
          bm_ctl.idx         = pslot_r[pw][SLOT_W-1:0];
          pw_we              = 1'b1;
          pw_frame           = rd_r;
          pw_slot            = {1'b0, slot_r};
        end else begin
          bm_ctl.set_garbage = 1'b1;
          bm_ctl.idx         = slot_r;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        rs_hit_nxt = rs_hit_r;
        rs_fl_nxt  = rs_fl_r;
        rs_st_nxt  = rs_st_r;
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_W'(SLOTS);
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HASH_WAYS; i++) begin
        pframe_r[i] <= '1;
        pslot_r[i]  <= LIM_W'(SLOTS);
        prefs_r[i]  <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      if (cfg_we) cfg_r <= cfg_wdata;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (pw_we) begin
        pframe_r[pw] <= pw_frame;
        pslot_r[pw]  <= pw_slot;
        prefs_r[pw]  <= pw_refs;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    start_r    <= start_nxt;
    wrap_r     <= wrap_nxt;
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    rs_slot_r  <= rs_slot_nxt;
    rs_frame_r <= rs_frame_nxt;
    rs_hit_r   <= rs_hit_nxt;
    rs_fl_r    <= rs_fl_nxt;
    rs_st_r    <= rs_st_nxt;
    if (accept) begin
      op_r    <= in_opcode;
      frame_r <= in_frame;
      slot_r  <= in_slot;
    end
    if (out_load) begin
      out_slot_r  <= rs_slot_r;
      out_frame_r <= rs_frame_r;
      out_hit_r   <= rs_hit_r;
      out_fl_r    <= rs_fl_r;
      out_st_r    <= rs_st_r;
    end
  end

  // Slot frame store: write on commit, read on each accept.
  always_ff @(posedge clk) begin
    if (mem_we) frame_mem[idx_r] <= frame_r;
    if (accept) rd_r <= frame_mem[in_slot];
  end

  assign out_valid     = out_valid_r;
  assign out_slot_out  = out_slot_r;
  assign out_frame_out = out_frame_r;
  assign out_hash_hit  = out_hit_r;
  assign out_flushed   = out_fl_r;
  assign out_status    = out_st_r;

  // Checks.
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state not one-hot");
  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= LIM_W'(SLOTS))
    else $error("search cursor past slot count");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("result beat not presented");
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMMIT |-> op_r == OP_MAP && {1'b0, idx_r} < lim)
    else $error("commit of slot outside limit");

endmodule

>>> bench/tb.sv
// Self-checking testbench for the page map slot cache: predictor, driver, monitor.
module tb
  import pmsc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                  op;
    logic [FRAME_BITS-1:0] frame;
    logic [SLOT_W-1:0]     slot;
  } page_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]     slot;
    logic [FRAME_BITS-1:0] frame;
    logic                  hit;
    logic                  flushed;
    logic [1:0]            status;
  } slot_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_opcode = OP_MAP;
  logic [FRAME_BITS-1:0] in_frame = '0;
  logic [SLOT_W-1:0]     in_slot = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SLOT_W-1:0]     out_slot_out;
  logic [FRAME_BITS-1:0] out_frame_out;
  logic                  out_hash_hit;
  logic                  out_flushed;
  logic [1:0]            out_status;

  page_map_slot_cache dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_frame(in_frame), .in_slot(in_slot), .out_valid(out_valid),
    .out_ready(out_ready), .out_slot_out(out_slot_out),
    .out_frame_out(out_frame_out), .out_hash_hit(out_hash_hit),
    .out_flushed(out_flushed), .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the allocator state
  bit                    busy_bits [SLOTS];
  bit                    garbage_bits [SLOTS];
  bit                    frame_known [SLOTS];
  logic [FRAME_BITS-1:0] held_frame [SLOTS];
  int                    cursor;
  logic [FRAME_BITS-1:0] parked_frame [HASH_WAYS];
  int                    parked_slot [HASH_WAYS];
  int                    parked_refs [HASH_WAYS];
  int                    slot_limit;
  int                    last_grant;

  page_req_t             pending_reqs [$];
  slot_result_t          awaited_results [$];
  int                    known_slots [$];
  logic [FRAME_BITS-1:0] recent_frames [$];
  int                    send_idle;
  int                    recv_idle;
  int                    errors;

  function automatic slot_result_t pack_result(int s, logic [FRAME_BITS-1:0] f,
                                               bit h, bit fl, logic [1:0] st);
    slot_result_t r;
    r.slot = s[SLOT_W-1:0];
    r.frame = f;
    r.hit = h;
    r.flushed = fl;
    r.status = st;
    return r;
  endfunction

  function automatic slot_result_t map_frame(logic [FRAME_BITS-1:0] f);
    int w;
    int k;
    int idx;
    bit wrapped;
    w = int'(f[WAY_W-1:0]);
    idx = -1;
    wrapped = 1'b0;
    // probe the parked mapping of this way
    if (parked_slot[w] < SLOTS && parked_frame[w] == f) begin
      if (parked_refs[w] >= int'(REFS_MAX))
        return pack_result(parked_slot[w], f, 1'b1, 1'b0, ST_REFS);
      parked_refs[w]++;
      return pack_result(parked_slot[w], f, 1'b1, 1'b0, ST_OK);
    end
    for (int i = cursor; i < slot_limit; i++)
      if (!busy_bits[i]) begin
        idx = i;
        break;
      end
    if (idx < 0) begin
      // wrap: reclaim garbage, search again, then evict an idle way
      wrapped = 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
        if (garbage_bits[i]) busy_bits[i] = 1'b0;
        garbage_bits[i] = 1'b0;
      end
      for (int i = 0; i < slot_limit; i++)
        if (!busy_bits[i]) begin
          idx = i;
          break;
        end
      k = w;
      for (int n = 0; n < HASH_WAYS && idx < 0; n++) begin
        if (parked_slot[k] < slot_limit && parked_refs[k] == 0) begin
          idx = parked_slot[k];
          parked_slot[k] = SLOTS;
          parked_frame[k] = '1;
        end
        k = (k + 1) % HASH_WAYS;
      end
      if (idx < 0) return pack_result(0, f, 1'b0, 1'b1, ST_NO_SLOT);
    end
    busy_bits[idx] = 1'b1;
    cursor = idx + 1;
    held_frame[idx] = f;
    if (!frame_known[idx]) known_slots.push_back(idx);
    frame_known[idx] = 1'b1;
    last_grant = idx;
    return pack_result(idx, f, 1'b0, wrapped, ST_OK);
  endfunction

  function automatic slot_result_t unmap_slot(int idx);
    logic [FRAME_BITS-1:0] f;
    int w;
    if (idx >= slot_limit) return pack_result(idx, '0, 1'b0, 1'b0, ST_OK);
    f = held_frame[idx];
    w = int'(f[WAY_W-1:0]);
    if (parked_slot[w] == idx) begin
      if (parked_refs[w] == 0) return pack_result(idx, f, 1'b0, 1'b0, ST_REFS);
      parked_refs[w]--;
    end else if (parked_refs[w] == 0) begin
      // park the slot, retire the previous occupant to garbage
      if (parked_slot[w] < SLOTS) garbage_bits[parked_slot[w]] = 1'b1;
      parked_frame[w] = f;
      parked_slot[w] = idx;
    end else begin
      garbage_bits[idx] = 1'b1;
    end
    return pack_result(idx, f, 1'b0, 1'b0, ST_OK);
  endfunction

  // Driver: predict on each accepted beat, then offer the next one
  always @(posedge clk) begin
    page_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        awaited_results.push_back(in_opcode == OP_MAP ? map_frame(in_frame)
                                                      : unmap_slot(int'(in_slot)));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_opcode <= req.op;
          in_frame <= req.frame;
          in_slot <= req.slot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, check each result beat in order
  always @(posedge clk) begin
    slot_result_t got;
    slot_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = pack_result(int'(out_slot_out), out_frame_out, out_hash_hit,
                          out_flushed, out_status);
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result slot=%0d frame=%h hit=%b fl=%b st=%0d",
                   $time, got.slot, got.frame, got.hit, got.flushed, got.status);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t mismatch exp slot=%0d frame=%h hit=%b fl=%b st=%0d",
                     $time, want.slot, want.frame, want.hit, want.flushed, want.status);
            $display("%0t          got slot=%0d frame=%h hit=%b fl=%b st=%0d",
                     $time, got.slot, got.frame, got.hit, got.flushed, got.status);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic push_req(logic op, logic [FRAME_BITS-1:0] f, int s);
    page_req_t req;
    req.op = op;
    req.frame = f;
    req.slot = s[SLOT_W-1:0];
    pending_reqs.push_back(req);
    if (op == OP_MAP) begin
      recent_frames.push_back(f);
      if (recent_frames.size() > 12) void'(recent_frames.pop_front());
    end
  endtask

  // Wait until every queued beat has been accepted
  task automatic drain_inputs();
    do @(negedge clk); while (pending_reqs.size() > 0 || in_valid);
  endtask

  // Wait for all results, then idle before the next phase
  task automatic settle();
    drain_inputs();
    while (awaited_results.size() > 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_limit(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    slot_limit = (v % 2048) < SLOTS ? (v % 2048) : SLOTS;
  endtask

  function automatic logic [FRAME_BITS-1:0] pick_frame();
    logic [63:0] wide;
    int sel;
    wide = {$urandom, $urandom};
    sel = $urandom_range(9);
    if (sel < 4 && recent_frames.size() > 0)
      return recent_frames[$urandom_range(recent_frames.size() - 1)];
    if (sel < 6) return FRAME_BITS'($urandom_range(15));
    if (sel == 6) return {wide[FRAME_BITS-1:WAY_W+4], {(WAY_W+4){1'b1}}};
    return wide[FRAME_BITS-1:0];
  endfunction

  // Random beats in small batches, so unmaps name slots already mapped or past the limit
  task automatic random_beats(int count);
    int s;
    bit is_map;
    for (int b = 0; b < count; b += 8) begin
      for (int i = 0; i < 8; i++) begin
        s = $urandom_range(SLOTS - 1);
        is_map = ($urandom_range(99) < 55);
        if (!is_map && s < slot_limit && !frame_known[s]) begin
          if (known_slots.size() > 0 && $urandom_range(9) > 0)
            s = known_slots[$urandom_range(known_slots.size() - 1)];
          else if (slot_limit < SLOTS)
            s = $urandom_range(SLOTS - 1, slot_limit);
          else
            is_map = 1'b1;
        end
        push_req(is_map ? OP_MAP : OP_UNMAP,
                 is_map ? pick_frame() : FRAME_BITS'({$urandom, $urandom}), s);
      end
      drain_inputs();
    end
  endtask

  initial begin
    int      slot_x;
    int      way_x;
    logic [FRAME_BITS-1:0] frame_x;
    errors = 0;
    cursor = 0;
    slot_limit = SLOTS;
    last_grant = 0;
    for (int i = 0; i < SLOTS; i++) begin
      busy_bits[i] = 1'b0;
      garbage_bits[i] = 1'b0;
      frame_known[i] = 1'b0;
      held_frame[i] = '0;
    end
    for (int i = 0; i < HASH_WAYS; i++) begin
      parked_frame[i] = '1;
      parked_slot[i] = SLOTS;
      parked_refs[i] = 0;
    end
    send_idle = 34;
    recv_idle = 88;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_limit(SLOTS);

    // directed: extremes, hits, parking, garbage and underflow
    push_req(OP_MAP, '0, 0);
    push_req(OP_MAP, '1, SLOTS - 1);
    push_req(OP_MAP, FRAME_BITS'(HASH_WAYS), 0);
    push_req(OP_UNMAP, '1, 0);
    push_req(OP_MAP, '0, 0);
    push_req(OP_UNMAP, '0, 0);
    push_req(OP_UNMAP, '0, 0);
    push_req(OP_UNMAP, '0, 2);
    push_req(OP_MAP, FRAME_BITS'(HASH_WAYS), 0);
    push_req(OP_MAP, FRAME_BITS'(HASH_WAYS), 0);
    push_req(OP_UNMAP, '0, 2);
    push_req(OP_UNMAP, '0, 1);
    push_req(OP_MAP, '1, 0);
    push_req(OP_UNMAP, '0, 1);
    push_req(OP_MAP, 40'h12_3456_7891, 0);
    random_beats(72);
    settle();

    // tight limits drive the wrap, reclaim, eviction and no-slot paths
    write_limit(5);
    random_beats(80);
    settle();
    send_idle = 88;
    recv_idle = 34;
    write_limit(1);
    random_beats(64);
    settle();
    write_limit(0);
    random_beats(24);
    settle();
    write_limit(2047);
    random_beats(80);
    settle();
    send_idle = 0;
    recv_idle = 0;
    write_limit(37);
    random_beats(80);
    settle();
    write_limit(SLOTS);
    random_beats(40);
    settle();

    // repeated hits and an underflow on one parked mapping
    way_x = 0;
    for (int i = HASH_WAYS - 1; i >= 0; i--)
      if (parked_refs[i] == 0) way_x = i;
    frame_x = {FRAME_BITS'({$urandom, $urandom}) >> WAY_W, WAY_W'(way_x)};
    push_req(OP_MAP, frame_x, 0);
    drain_inputs();
    slot_x = last_grant;
    push_req(OP_UNMAP, '0, slot_x);
    push_req(OP_UNMAP, '0, slot_x);
    for (int i = 0; i < 8; i++) push_req(OP_MAP, frame_x, 0);
    push_req(OP_UNMAP, '0, slot_x);
    settle();

    if (errors == 0)
      $display("page_map_slot_cache verification clean");
    else
      $display("page_map_slot_cache verification failed");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("page_map_slot_cache verification failed");
    $finish;
  end

endmodule
